@@ sv/sitda_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII converter.
package sitda_pkg;

  // Input word and output character widths.
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 8;

  // Ten BCD digits hold any 32-bit magnitude.
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int SHIFT_CNT_W = $clog2(VALUE_W);

  // ASCII codes used in the output text.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  // BCD adjust threshold and offset for the shift-and-add-3 conversion.
  localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD   = 4'd3;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef digit_t [NUM_DIGITS-1:0] bcd_vec_t;
  typedef logic [VALUE_W-1:0] mag_t;

endpackage

@@ sv/signed_int_to_decimal_ascii.sv @@
// Top level: converts a signed 32-bit integer to its decimal ASCII text, one character per transfer.
// An input transfer runs through 32 shift-and-adjust steps in the shared BCD unit, one
// leading-digit scan and one output load before the first character appears.
// Each item gives n = 1..11 characters, sent one character per cycle while the output side
// takes them; a new input is accepted only after the last character of the item is loaded.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the output register.
module signed_int_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sitda_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sitda_pkg::CHAR_W-1:0]        out_character,
  output logic                                out_last
);
  import sitda_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   neg_r, neg_nxt;
  mag_t                   mag_r, mag_nxt;
  bcd_vec_t               bcd_r, bcd_nxt;
  logic [SHIFT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIGIT_IDX_W-1:0] idx_r, idx_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_character_r, out_character_nxt;
  logic                   out_last_r, out_last_nxt;

  bcd_vec_t               bcd_adj;
  logic [DIGIT_IDX_W-1:0] lead_idx;
  logic                   out_free;
  logic                   in_xfer;

  assign in_ready      = (state_r == ST_IDLE);
  assign in_xfer       = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;
  assign out_free      = !out_valid_r || out_ready;

  // Shared BCD unit: add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] >= BCD_ADJ_LIMIT) begin
        bcd_adj[i] = bcd_r[i] + BCD_ADJ_ADD;
      end else begin
        bcd_adj[i] = bcd_r[i];
      end
    end
  end

  // Position of the most significant nonzero digit; zero gives the lowest digit.
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != '0) begin
        lead_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  // Sequencer and output register next-state logic.
  always_comb begin
    state_nxt         = state_r;
    neg_nxt           = neg_r;
    mag_nxt           = mag_r;
    bcd_nxt           = bcd_r;
    cnt_nxt           = cnt_r;
    idx_nxt           = idx_r;
    out_valid_nxt     = out_valid_r;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;

    // A waiting character leaves when the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt   = in_value[VALUE_W-1];
          mag_nxt   = in_value[VALUE_W-1] ? (mag_t'(0) - mag_t'(in_value)) : mag_t'(in_value);
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // One binary bit moves into the BCD digits each cycle.
        {bcd_nxt, mag_nxt} = {bcd_adj, mag_r} << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SHIFT_CNT_W'(VALUE_W - 1)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_nxt   = lead_idx;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (neg_r) begin
            out_character_nxt = ASCII_MINUS;
            out_last_nxt      = 1'b0;
            neg_nxt           = 1'b0;
          end else begin
            out_character_nxt = ASCII_ZERO + CHAR_W'(bcd_r[idx_r]);
            out_last_nxt      = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, working registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r           <= neg_nxt;
    mag_r           <= mag_nxt;
    bcd_r           <= bcd_nxt;
    cnt_r           <= cnt_nxt;
    idx_r           <= idx_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
  end

endmodule
